/* rtl/csa_pkg.sv */
// Shared types and constants for the call argument slot allocator.
`default_nettype none

package csa_pkg;

    localparam int OFFSET_BITS_DEFAULT = 16;

    localparam logic [2:0] NUM_REGS          = 3'd4;
    localparam logic [15:0] BIG_STRUCT_BYTES = 16'd16;
    localparam logic [15:0] PTR_BYTES        = 16'd4;
    localparam logic [4:0] WORD_BYTES        = 5'd4;
    localparam logic [4:0] DWORD_BYTES       = 5'd8;
    localparam logic [2:0] WORD_ALIGN_LOG2   = 3'd2;
    localparam logic [2:0] DWORD_ALIGN_LOG2  = 3'd3;
    localparam logic [2:0] NO_ALIGN_LOG2     = 3'd0;
    localparam logic [2:0] STACK_ALIGN_RESET = 3'd3;

    localparam logic [1:0] KIND_WORD   = 2'd0;
    localparam logic [1:0] KIND_DWORD  = 2'd1;
    localparam logic [1:0] KIND_STRUCT = 2'd2;

    localparam logic [1:0] LOC_REGS  = 2'd0;
    localparam logic [1:0] LOC_STACK = 2'd1;
    localparam logic [1:0] LOC_SPLIT = 2'd2;

    typedef struct packed {
        logic        new_call;
        logic [7:0]  arg_pos;
        logic [1:0]  arg_kind;
        logic [15:0] arg_size;
        logic [2:0]  arg_align_log2;
    } arg_t;

    typedef struct packed {
        logic [1:0]  loc_kind;
        logic [2:0]  base_reg;
        logic [2:0]  reg_used;
        logic [15:0] stack_offset;
        logic [15:0] stack_part_bytes;
        logic [15:0] passed_bytes;
        logic        invisible_ref;
        logic [15:0] frame_bytes;
        logic [8:0]  arg_total;
        logic        overflow;
    } slot_t;

    typedef struct packed {
        logic [2:0] next_register;
        logic [8:0] argument_count;
    } ctr_t;

endpackage

`default_nettype wire

/* rtl/call_argument_slot_allocator.sv */
// Top level of the call argument slot allocator: beat registers, allocation state and config.
`default_nettype none

// Takes one call argument per beat and returns where it is passed: core registers r0 to r3,
// the outgoing stack, or split between the two, together with the running frame size and
// argument count. A beat is accepted every cycle while the result side keeps up. An accepted
// beat is held in the argument register, and the classification logic between it and the
// result register loads the result once the result register is free to take it; the result
// is then offered on slot_valid until it is taken. The allocation state is updated as each
// beat moves into the result register, so consecutive arguments of a call see each other
// without a gap. Set new_call on the first argument of each call. The stack alignment
// register should be written only while no beat is in flight.
module call_argument_slot_allocator #(
    parameter int OFFSET_BITS = csa_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_write,
    input  logic [2:0]     cfg_data,
    input  logic           arg_valid,
    output logic           arg_stall,
    input  csa_pkg::arg_t  arg,
    output logic           slot_valid,
    input  logic           slot_stall,
    output csa_pkg::slot_t slot
);

    logic [2:0]             align_reg;
    logic [2:0]             align_next;
    logic                   arg_valid_reg;
    logic                   arg_valid_next;
    csa_pkg::arg_t          arg_reg;
    csa_pkg::arg_t          arg_next;
    csa_pkg::ctr_t          ctr_reg;
    csa_pkg::ctr_t          ctr_next;
    csa_pkg::ctr_t          ctr_calc;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [OFFSET_BITS-1:0] offset_next;
    logic [OFFSET_BITS-1:0] offset_calc;
    logic                   slot_valid_reg;
    logic                   slot_valid_next;
    csa_pkg::slot_t         slot_reg;
    csa_pkg::slot_t         slot_next;
    csa_pkg::slot_t         slot_calc;
    logic                   slot_free;
    logic                   advance;
    logic                   arg_take;

    csa_classify #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_classify (
        .arg              (arg_reg),
        .stack_align_log2 (align_reg),
        .ctr              (ctr_reg),
        .offset           (offset_reg),
        .slot             (slot_calc),
        .ctr_next         (ctr_calc),
        .offset_next      (offset_calc)
    );

    always_comb
    begin
        slot_free = !slot_valid_reg || !slot_stall;
        advance   = arg_valid_reg && slot_free;
        arg_stall = arg_valid_reg && !slot_free;
        arg_take  = arg_valid && !arg_stall;

        align_next      = cfg_write ? cfg_data : align_reg;
        arg_valid_next  = arg_take || (arg_valid_reg && !advance);
        arg_next        = arg_take ? arg : arg_reg;
        ctr_next        = advance ? ctr_calc : ctr_reg;
        offset_next     = advance ? offset_calc : offset_reg;
        slot_valid_next = advance || (slot_valid_reg && slot_stall);
        slot_next       = advance ? slot_calc : slot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            align_reg      <= csa_pkg::STACK_ALIGN_RESET;
            arg_valid_reg  <= 1'b0;
            ctr_reg        <= '0;
            offset_reg     <= '0;
            slot_valid_reg <= 1'b0;
        end
        else
        begin
            align_reg      <= align_next;
            arg_valid_reg  <= arg_valid_next;
            ctr_reg        <= ctr_next;
            offset_reg     <= offset_next;
            slot_valid_reg <= slot_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        arg_reg  <= arg_next;
        slot_reg <= slot_next;
    end

    assign slot_valid = slot_valid_reg;
    assign slot       = slot_reg;

endmodule

`default_nettype wire

/* rtl/csa_classify.sv */
// Combinational classification of one argument against the current allocation state.
`default_nettype none

module csa_classify #(
    parameter int OFFSET_BITS = csa_pkg::OFFSET_BITS_DEFAULT
) (
    input  csa_pkg::arg_t           arg,
    input  logic [2:0]              stack_align_log2,
    input  csa_pkg::ctr_t           ctr,
    input  logic [OFFSET_BITS-1:0]  offset,
    output csa_pkg::slot_t          slot,
    output csa_pkg::ctr_t           ctr_next,
    output logic [OFFSET_BITS-1:0]  offset_next
);

    localparam int OBW = OFFSET_BITS + 1;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    logic [2:0]             reg_cur;
    logic [2:0]             reg_even;
    logic [2:0]             reg_new;
    logic [2:0]             alog;
    logic [2:0]             slog;
    logic [2:0]             stack_log;
    logic [8:0]             count_cur;
    logic [8:0]             count_idx;
    logic [OFFSET_BITS-1:0] off_cur;
    logic [OFFSET_BITS-1:0] off_aligned;
    logic [OFFSET_BITS-1:0] off_adv;
    logic [OFFSET_BITS-1:0] off_new;
    logic [OBW-1:0]         sum_aligned;
    logic [OBW-1:0]         sum_adv;
    logic [OBW-1:0]         sum_frame;
    logic [4:0]             stack_add;
    logic [2:0]             words;
    logic [2:0]             avail;
    logic [2:0]             rest;
    logic                   big;
    logic                   use_stack;
    logic                   sat_align;
    logic                   sat_adv;
    logic                   sat_frame;

    // Rounds up to a power-of-two boundary; the top bit flags a result beyond the offset range.
    function automatic logic [OBW-1:0] align_up(input logic [OFFSET_BITS-1:0] v,
                                                input logic [2:0] lg);
        logic [OBW-1:0] mask;
        mask = ({{(OBW-1){1'b0}}, 1'b1} << lg) - {{(OBW-1){1'b0}}, 1'b1};
        return ({1'b0, v} + mask) & ~mask;
    endfunction

    always_comb
    begin
        reg_cur   = arg.new_call ? 3'd0 : ctr.next_register;
        off_cur   = arg.new_call ? '0 : offset;
        count_cur = arg.new_call ? 9'd0 : ctr.argument_count;
        count_idx = {1'b0, arg.arg_pos} + 9'd1;

        alog = (arg.arg_align_log2 < csa_pkg::WORD_ALIGN_LOG2) ?
               csa_pkg::WORD_ALIGN_LOG2 : arg.arg_align_log2;
        slog = (stack_align_log2 < csa_pkg::WORD_ALIGN_LOG2) ?
               csa_pkg::WORD_ALIGN_LOG2 : stack_align_log2;

        reg_even = reg_cur + {2'b00, reg_cur[0]};
        big      = arg.arg_size > csa_pkg::BIG_STRUCT_BYTES;
        words    = 3'(({1'b0, arg.arg_size[4:0]} + 6'd3) >> 2);
        avail    = csa_pkg::NUM_REGS - reg_cur;
        rest     = words - avail;

        slot                  = '0;
        slot.loc_kind         = csa_pkg::LOC_REGS;
        slot.passed_bytes     = arg.arg_size;
        reg_new               = reg_cur;
        use_stack             = 1'b0;
        stack_log             = csa_pkg::NO_ALIGN_LOG2;
        stack_add             = 5'd0;

        unique case (arg.arg_kind)
            csa_pkg::KIND_DWORD:
            begin
                if (reg_even <= 3'd2)
                begin
                    slot.base_reg = reg_even;
                    slot.reg_used = 3'd2;
                    reg_new       = reg_even + 3'd2;
                end
                else
                begin
                    slot.loc_kind = csa_pkg::LOC_STACK;
                    use_stack     = 1'b1;
                    stack_log     = csa_pkg::DWORD_ALIGN_LOG2;
                    stack_add     = csa_pkg::DWORD_BYTES;
                    reg_new       = csa_pkg::NUM_REGS;
                end
            end
            csa_pkg::KIND_STRUCT:
            begin
                if (big)
                begin
                    slot.invisible_ref = 1'b1;
                    slot.passed_bytes  = csa_pkg::PTR_BYTES;
                    if (reg_cur < csa_pkg::NUM_REGS)
                    begin
                        slot.base_reg = reg_cur;
                        slot.reg_used = 3'd1;
                        reg_new       = reg_cur + 3'd1;
                    end
                    else
                    begin
                        slot.loc_kind = csa_pkg::LOC_STACK;
                        use_stack     = 1'b1;
                        stack_add     = csa_pkg::WORD_BYTES;
                    end
                end
                else if (({1'b0, reg_cur} + {1'b0, words}) <= {1'b0, csa_pkg::NUM_REGS})
                begin
                    slot.reg_used = words;
                    slot.base_reg = (words != 3'd0) ? reg_cur : 3'd0;
                    reg_new       = reg_cur + words;
                end
                else if (reg_cur < csa_pkg::NUM_REGS)
                begin
                    slot.loc_kind         = csa_pkg::LOC_SPLIT;
                    slot.base_reg         = reg_cur;
                    slot.reg_used         = avail;
                    slot.stack_part_bytes = {11'd0, rest, 2'b00};
                    use_stack             = 1'b1;
                    stack_log             = alog;
                    stack_add             = {rest, 2'b00};
                    reg_new               = csa_pkg::NUM_REGS;
                end
                else
                begin
                    slot.loc_kind = csa_pkg::LOC_STACK;
                    use_stack     = 1'b1;
                    stack_log     = alog;
                    stack_add     = {words, 2'b00};
                    reg_new       = csa_pkg::NUM_REGS;
                end
            end
            default:
            begin
                if (reg_cur < csa_pkg::NUM_REGS)
                begin
                    slot.base_reg = reg_cur;
                    slot.reg_used = 3'd1;
                    reg_new       = reg_cur + 3'd1;
                end
                else
                begin
                    slot.loc_kind = csa_pkg::LOC_STACK;
                    use_stack     = 1'b1;
                    stack_log     = csa_pkg::WORD_ALIGN_LOG2;
                    stack_add     = csa_pkg::WORD_BYTES;
                    reg_new       = csa_pkg::NUM_REGS;
                end
            end
        endcase

        sum_aligned = align_up(off_cur, stack_log);
        sat_align   = sum_aligned[OBW-1];
        off_aligned = sat_align ? OFF_MAX : sum_aligned[OBW-2:0];

        sum_adv = {1'b0, off_aligned} + OBW'(stack_add);
        sat_adv = sum_adv[OBW-1];
        off_adv = sat_adv ? OFF_MAX : sum_adv[OBW-2:0];

        off_new   = use_stack ? off_adv : off_cur;
        sum_frame = align_up(off_new, slog);
        sat_frame = sum_frame[OBW-1];

        slot.stack_offset = use_stack ? 16'(off_aligned) : 16'd0;
        slot.frame_bytes  = sat_frame ? 16'(OFF_MAX) : 16'(sum_frame[OBW-2:0]);
        slot.arg_total    = (count_cur < count_idx) ? count_idx : count_cur;
        slot.overflow     = (use_stack & (sat_align | sat_adv)) | sat_frame;

        ctr_next.next_register  = reg_new;
        ctr_next.argument_count = slot.arg_total;
        offset_next             = off_new;
    end

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for the call argument slot allocator, with a predictor and random beats.
module testbench;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam longint OFFSET_LIMIT = (longint'(1) << csa_pkg::OFFSET_BITS_DEFAULT) - 1;
    localparam int QUIET_LIMIT = 2000;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [2:0] cfg_data;
    logic arg_valid;
    logic arg_stall;
    csa_pkg::arg_t arg;
    logic slot_valid;
    logic slot_stall;
    csa_pkg::slot_t slot;

    csa_pkg::slot_t pending_slots[$];
    csa_pkg::slot_t due;
    int mismatches;
    int quiet_cycles;
    int stall_left;
    bit bursty;

    int model_reg;
    longint next_offset;
    int arg_count;
    logic [2:0] align_model;
    bit offset_saturated;

    call_argument_slot_allocator dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_data(cfg_data),
        .arg_valid(arg_valid),
        .arg_stall(arg_stall),
        .arg(arg),
        .slot_valid(slot_valid),
        .slot_stall(slot_stall),
        .slot(slot)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic longint clamp_offset(input longint v);
        if (v > OFFSET_LIMIT)
        begin
            offset_saturated = 1'b1;
            return OFFSET_LIMIT;
        end
        return v;
    endfunction

    function automatic longint align_offset(input longint v, input int lg);
        longint step;
        step = longint'(1) << (lg & 7);
        return clamp_offset((v + step - 1) & ~(step - 1));
    endfunction

    function automatic csa_pkg::slot_t predict_slot(input csa_pkg::arg_t a);
        csa_pkg::slot_t r;
        int alog;
        int slog;
        int words;
        int avail;
        longint soff;
        longint spart;
        longint frame;
        r = '0;
        soff = 0;
        spart = 0;
        offset_saturated = 1'b0;
        if (a.new_call)
        begin
            model_reg = 0;
            next_offset = 0;
            arg_count = 0;
        end
        if (arg_count < int'(a.arg_pos) + 1)
            arg_count = int'(a.arg_pos) + 1;
        alog = (a.arg_align_log2 < csa_pkg::WORD_ALIGN_LOG2) ?
               int'(csa_pkg::WORD_ALIGN_LOG2) : int'(a.arg_align_log2);
        slog = (align_model < csa_pkg::WORD_ALIGN_LOG2) ?
               int'(csa_pkg::WORD_ALIGN_LOG2) : int'(align_model);
        r.loc_kind = csa_pkg::LOC_REGS;
        r.passed_bytes = a.arg_size;
        if (a.arg_kind == csa_pkg::KIND_DWORD)
        begin
            if (model_reg % 2 == 1)
                model_reg++;
            if (model_reg <= 2)
            begin
                r.base_reg = 3'(model_reg);
                r.reg_used = 3'd2;
                model_reg += 2;
            end
            else
            begin
                next_offset = align_offset(next_offset, int'(csa_pkg::DWORD_ALIGN_LOG2));
                r.loc_kind = csa_pkg::LOC_STACK;
                soff = next_offset;
                next_offset = clamp_offset(next_offset + csa_pkg::DWORD_BYTES);
                model_reg = int'(csa_pkg::NUM_REGS);
            end
        end
        else if (a.arg_kind == csa_pkg::KIND_STRUCT)
        begin
            words = (int'(a.arg_size) + 3) / 4;
            if (a.arg_size > csa_pkg::BIG_STRUCT_BYTES)
            begin
                r.invisible_ref = 1'b1;
                r.passed_bytes = csa_pkg::PTR_BYTES;
                if (model_reg < int'(csa_pkg::NUM_REGS))
                begin
                    r.base_reg = 3'(model_reg);
                    r.reg_used = 3'd1;
                    model_reg++;
                end
                else
                begin
                    r.loc_kind = csa_pkg::LOC_STACK;
                    soff = next_offset;
                    next_offset = clamp_offset(next_offset + csa_pkg::PTR_BYTES);
                end
            end
            else if (model_reg + words <= int'(csa_pkg::NUM_REGS))
            begin
                r.reg_used = 3'(words);
                r.base_reg = (words != 0) ? 3'(model_reg) : 3'd0;
                model_reg += words;
            end
            else if (model_reg < int'(csa_pkg::NUM_REGS))
            begin
                avail = int'(csa_pkg::NUM_REGS) - model_reg;
                r.loc_kind = csa_pkg::LOC_SPLIT;
                r.base_reg = 3'(model_reg);
                r.reg_used = 3'(avail);
                next_offset = align_offset(next_offset, alog);
                soff = next_offset;
                spart = longint'(words - avail) * csa_pkg::WORD_BYTES;
                next_offset = clamp_offset(next_offset + spart);
                model_reg = int'(csa_pkg::NUM_REGS);
            end
            else
            begin
                next_offset = align_offset(next_offset, alog);
                r.loc_kind = csa_pkg::LOC_STACK;
                soff = next_offset;
                next_offset = clamp_offset(next_offset + longint'(words) * csa_pkg::WORD_BYTES);
                model_reg = int'(csa_pkg::NUM_REGS);
            end
        end
        else
        begin
            if (model_reg < int'(csa_pkg::NUM_REGS))
            begin
                r.base_reg = 3'(model_reg);
                r.reg_used = 3'd1;
                model_reg++;
            end
            else
            begin
                next_offset = align_offset(next_offset, int'(csa_pkg::WORD_ALIGN_LOG2));
                r.loc_kind = csa_pkg::LOC_STACK;
                soff = next_offset;
                next_offset = clamp_offset(next_offset + csa_pkg::WORD_BYTES);
                model_reg = int'(csa_pkg::NUM_REGS);
            end
        end
        frame = align_offset(next_offset, slog);
        r.stack_offset = soff[15:0];
        r.stack_part_bytes = spart[15:0];
        r.frame_bytes = frame[15:0];
        r.arg_total = 9'(arg_count);
        r.overflow = offset_saturated;
        return r;
    endfunction

    function automatic csa_pkg::arg_t arg_of(input bit nc, input int idx, input logic [1:0] kind,
                                             input int size, input int alog);
        csa_pkg::arg_t a;
        a.new_call = nc;
        a.arg_pos = 8'(idx);
        a.arg_kind = kind;
        a.arg_size = 16'(size);
        a.arg_align_log2 = 3'(alog);
        return a;
    endfunction

    function automatic csa_pkg::arg_t random_arg(input bit first, input int pos);
        csa_pkg::arg_t a;
        a.new_call = first || ($urandom_range(0, 40) == 0);
        a.arg_pos = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'(pos);
        if ($urandom_range(0, 15) == 0)
            a.arg_kind = KIND_UNUSED;
        else
            a.arg_kind = 2'($urandom_range(0, 2));
        if (a.arg_kind == csa_pkg::KIND_STRUCT && $urandom_range(0, 3) != 0)
            a.arg_size = 16'($urandom_range(0, 20));
        else
            a.arg_size = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 7) == 0)
            a.arg_align_log2 = 3'($urandom_range(5, 7));
        else
            a.arg_align_log2 = 3'($urandom_range(0, 4));
        return a;
    endfunction

    task automatic report_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic send_arg(input csa_pkg::arg_t a);
        int gap;
        if (bursty && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 8);
            arg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        arg <= a;
        arg_valid <= 1'b1;
        @(posedge clk);
        while (arg_stall)
            @(posedge clk);
        pending_slots.push_back(predict_slot(a));
    endtask

    task automatic send_random_calls(input int items);
        int sent;
        int len;
        sent = 0;
        while (sent < items)
        begin
            len = $urandom_range(1, 10);
            for (int i = 0; i < len && sent < items; i++)
            begin
                send_arg(random_arg(i == 0, i));
                sent++;
            end
        end
    endtask

    task automatic wait_idle();
        arg_valid <= 1'b0;
        while (pending_slots.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_stack_align(input logic [2:0] value);
        cfg_data <= value;
        cfg_write <= 1'b1;
        @(posedge clk);
        cfg_write <= 1'b0;
        align_model = value;
    endtask

    task automatic test_register_classes();
        send_arg(arg_of(1'b1, 0, csa_pkg::KIND_WORD, 4, 2));
        send_arg(arg_of(1'b0, 1, csa_pkg::KIND_DWORD, 8, 3));
        send_arg(arg_of(1'b0, 2, csa_pkg::KIND_WORD, 4, 0));
        send_arg(arg_of(1'b0, 3, csa_pkg::KIND_DWORD, 8, 3));
        send_arg(arg_of(1'b0, 255, KIND_UNUSED, 65535, 7));
        send_arg(arg_of(1'b1, 0, csa_pkg::KIND_WORD, 0, 0));
        send_arg(arg_of(1'b0, 1, csa_pkg::KIND_WORD, 4, 1));
        send_arg(arg_of(1'b0, 2, KIND_UNUSED, 4, 2));
        send_arg(arg_of(1'b0, 3, csa_pkg::KIND_DWORD, 8, 4));
        send_arg(arg_of(1'b1, 0, csa_pkg::KIND_DWORD, 8, 3));
    endtask

    task automatic test_struct_classes();
        send_arg(arg_of(1'b1, 0, csa_pkg::KIND_STRUCT, 0, 2));
        send_arg(arg_of(1'b0, 1, csa_pkg::KIND_STRUCT, 5, 0));
        send_arg(arg_of(1'b0, 2, csa_pkg::KIND_STRUCT, 17, 2));
        send_arg(arg_of(1'b0, 3, csa_pkg::KIND_STRUCT, 16, 4));
        send_arg(arg_of(1'b0, 4, csa_pkg::KIND_STRUCT, 65535, 2));
        send_arg(arg_of(1'b0, 5, csa_pkg::KIND_STRUCT, 3, 7));
        send_arg(arg_of(1'b0, 6, csa_pkg::KIND_STRUCT, 16, 5));
        send_arg(arg_of(1'b0, 7, csa_pkg::KIND_STRUCT, 0, 6));
        send_arg(arg_of(1'b0, 8, csa_pkg::KIND_WORD, 4, 2));
        send_arg(arg_of(1'b1, 0, csa_pkg::KIND_WORD, 4, 2));
        send_arg(arg_of(1'b0, 1, csa_pkg::KIND_WORD, 4, 2));
        send_arg(arg_of(1'b0, 2, csa_pkg::KIND_STRUCT, 12, 6));
    endtask

    task automatic test_stack_saturation();
        wait_idle();
        set_stack_align(3'd7);
        send_arg(arg_of(1'b1, 0, csa_pkg::KIND_STRUCT, 16, 4));
        for (int i = 1; i <= 520; i++)
            send_arg(arg_of(1'b0, i, csa_pkg::KIND_STRUCT, 16, 7));
        send_arg(arg_of(1'b0, 200, csa_pkg::KIND_WORD, 4, 2));
        send_arg(arg_of(1'b0, 201, csa_pkg::KIND_DWORD, 8, 3));
        send_arg(arg_of(1'b0, 202, csa_pkg::KIND_STRUCT, 40, 2));
        send_arg(arg_of(1'b0, 203, csa_pkg::KIND_STRUCT, 8, 3));
        wait_idle();
        set_stack_align(3'd2);
    endtask

    task automatic test_alignment_settings();
        for (int v = 0; v < 8; v++)
        begin
            wait_idle();
            set_stack_align(3'(v));
            send_random_calls(24);
        end
    endtask

    task automatic test_random_calls();
        for (int phase = 0; phase < 7; phase++)
        begin
            wait_idle();
            set_stack_align(3'($urandom_range(0, 7)));
            bursty = (phase < 6) && ($urandom_range(0, 3) != 0);
            send_random_calls(80);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            slot_stall <= 1'b0;
            stall_left = 0;
            mismatches = 0;
        end
        else
        begin
            if (slot_valid && !slot_stall)
            begin
                if (pending_slots.size() == 0)
                begin
                    $error("beat arrived with no result expected");
                    mismatches++;
                end
                else
                begin
                    due = pending_slots.pop_front();
                    report_field("loc_kind", due.loc_kind, slot.loc_kind);
                    report_field("base_reg", due.base_reg, slot.base_reg);
                    report_field("reg_used", due.reg_used, slot.reg_used);
                    report_field("stack_offset", due.stack_offset, slot.stack_offset);
                    report_field("stack_part_bytes", due.stack_part_bytes,
                                 slot.stack_part_bytes);
                    report_field("passed_bytes", due.passed_bytes, slot.passed_bytes);
                    report_field("invisible_ref", due.invisible_ref, slot.invisible_ref);
                    report_field("frame_bytes", due.frame_bytes, slot.frame_bytes);
                    report_field("arg_total", due.arg_total, slot.arg_total);
                    report_field("overflow", due.overflow, slot.overflow);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                slot_stall <= 1'b1;
            end
            else if (bursty && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 7);
                slot_stall <= 1'b1;
            end
            else
            begin
                slot_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            if ((arg_valid && !arg_stall) || (slot_valid && !slot_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    initial
    begin
        bursty = 1'b1;
        model_reg = 0;
        next_offset = 0;
        arg_count = 0;
        align_model = csa_pkg::STACK_ALIGN_RESET;
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_data <= '0;
        arg_valid <= 1'b0;
        arg <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_classes();
        test_struct_classes();
        test_stack_saturation();
        test_alignment_settings();
        test_random_calls();
        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
